[rtl/fmg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmg_pkg
// Shared codes and the control word that travels from the front end to the
// divide/finish back end of the membership grade unit.
// ----------------------------------------------------------------------------
package fmg_pkg;

    // grade of 1.0
    localparam logic [16:0] ONE = 17'h10000;

    // shape codes
    localparam logic [2:0] SHAPE_RAMP_UP   = 3'd0;
    localparam logic [2:0] SHAPE_RAMP_DOWN = 3'd1;
    localparam logic [2:0] SHAPE_TRIANGLE  = 3'd2;
    localparam logic [2:0] SHAPE_TRAPEZOID = 3'd3;
    localparam logic [2:0] SHAPE_S_CURVE   = 3'd4;
    localparam logic [2:0] SHAPE_S_BELL    = 3'd5;
    localparam logic [2:0] SHAPE_INV_QUAD  = 3'd6;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SHAPE  = 3'd0,
        REG_A      = 3'd1,
        REG_B      = 3'd2,
        REG_C      = 3'd3,
        REG_D      = 3'd4,
        REG_SPREAD = 3'd5
    } reg_idx_t;

    // how the back end turns the quotient (or constant) into a grade
    typedef struct packed {
        logic        use_div;  // take the quotient, else cval
        logic        sq;       // S curve: 2*f*f >> 16
        logic        upper;    // S curve upper half: 1 - 2*g*g
        logic        invert;   // final 1 - grade
        logic [16:0] cval;     // constant grade
    } ctl_t;

    localparam int CTL_BITS = $bits(ctl_t);

endpackage : fmg_pkg
`default_nettype wire

[rtl/fmg_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmg_front
// Holds the configuration, classifies each sample against the breakpoints
// and forms the dividend and divisor. Two elastic stages.
// ----------------------------------------------------------------------------
module fmg_front #(
    parameter int VB = 16,
    parameter int CW = 16,
    parameter int NW = 33,
    parameter int DW = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [CW-1:0]        cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [VB-1:0]        in_sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output fmg_pkg::ctl_t             out_ctl,
    output logic [NW-1:0]             out_num,
    output logic [DW-1:0]             out_den
);

    localparam int SB = VB + 2;

    // configuration registers
    logic [2:0]    shape_reg;
    logic [VB-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [15:0]   spread_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg  <= 3'd0;
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            d_reg      <= '0;
            spread_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fmg_pkg::REG_SHAPE:  shape_reg  <= cfg_wdata[2:0];
                fmg_pkg::REG_A:      a_reg      <= cfg_wdata[VB-1:0];
                fmg_pkg::REG_B:      b_reg      <= cfg_wdata[VB-1:0];
                fmg_pkg::REG_C:      c_reg      <= cfg_wdata[VB-1:0];
                fmg_pkg::REG_D:      d_reg      <= cfg_wdata[VB-1:0];
                fmg_pkg::REG_SPREAD: spread_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // classification
    fmg_pkg::ctl_t       c_ctl;
    logic [VB:0]         c_num, c_den;
    logic                c_iq;
    logic signed [SB-1:0] sx, sa, sbp, sc, sdiff;
    logic [VB-1:0]       h, dd;
    logic [VB+12:0]      dd_ext;
    logic [23:0]         c_dsq;

    always_comb
    begin
        c_ctl  = '0;
        c_num  = '0;
        c_den  = '0;
        c_iq   = 1'b0;
        h      = b_reg >> 1;
        sx     = SB'(signed'({2'b00, in_sample}));
        sa     = SB'(signed'({2'b00, a_reg}));
        sbp    = SB'(signed'({2'b00, b_reg}));
        sc     = SB'(signed'({2'b00, c_reg}));
        sdiff  = '0;
        dd     = (in_sample >= a_reg) ? in_sample - a_reg : a_reg - in_sample;
        dd_ext = (VB+13)'(dd);
        c_dsq  = 24'(dd_ext[11:0] * dd_ext[11:0]);

        // S bell breakpoints around the center
        if (shape_reg == fmg_pkg::SHAPE_S_BELL)
        begin
            if (in_sample < c_reg)
            begin
                sa  = SB'(signed'({2'b00, c_reg})) - SB'(signed'({2'b00, b_reg}));
                sbp = SB'(signed'({2'b00, c_reg})) - SB'(signed'({2'b00, h}));
                sc  = SB'(signed'({2'b00, c_reg}));
            end
            else
            begin
                sa  = SB'(signed'({2'b00, c_reg}));
                sbp = SB'(signed'({2'b00, c_reg})) + SB'(signed'({2'b00, h}));
                sc  = SB'(signed'({2'b00, c_reg})) + SB'(signed'({2'b00, b_reg}));
                c_ctl.invert = 1'b1;
            end
        end

        unique case (shape_reg)
            fmg_pkg::SHAPE_RAMP_UP, fmg_pkg::SHAPE_RAMP_DOWN:
            begin
                c_ctl.invert = (shape_reg == fmg_pkg::SHAPE_RAMP_DOWN);
                if (in_sample < a_reg)
                    c_ctl.cval = '0;
                else if (in_sample >= b_reg)
                    c_ctl.cval = fmg_pkg::ONE;
                else
                begin
                    c_ctl.use_div = 1'b1;
                    c_num = (VB+1)'(in_sample - a_reg);
                    c_den = (VB+1)'(b_reg - a_reg);
                end
            end
            fmg_pkg::SHAPE_TRIANGLE:
            begin
                if (in_sample < a_reg || in_sample >= c_reg)
                    c_ctl.cval = '0;
                else if (in_sample < b_reg)
                begin
                    c_ctl.use_div = 1'b1;
                    c_num = (VB+1)'(in_sample - a_reg);
                    c_den = (VB+1)'(b_reg - a_reg);
                end
                else
                begin
                    c_ctl.use_div = 1'b1;
                    c_num = (VB+1)'(c_reg - in_sample);
                    c_den = (VB+1)'(c_reg - b_reg);
                end
            end
            fmg_pkg::SHAPE_TRAPEZOID:
            begin
                if (in_sample < a_reg || in_sample >= d_reg)
                    c_ctl.cval = '0;
                else if (in_sample >= b_reg && in_sample < c_reg)
                    c_ctl.cval = fmg_pkg::ONE;
                else if (in_sample < b_reg)
                begin
                    c_ctl.use_div = 1'b1;
                    c_num = (VB+1)'(in_sample - a_reg);
                    c_den = (VB+1)'(b_reg - a_reg);
                end
                else
                begin
                    c_ctl.use_div = 1'b1;
                    c_num = (VB+1)'(d_reg - in_sample);
                    c_den = (VB+1)'(d_reg - c_reg);
                end
            end
            fmg_pkg::SHAPE_S_CURVE, fmg_pkg::SHAPE_S_BELL:
            begin
                if (sx < sa)
                    c_ctl.cval = '0;
                else if (sx >= sc)
                    c_ctl.cval = fmg_pkg::ONE;
                else
                begin
                    c_ctl.use_div = 1'b1;
                    c_ctl.sq      = 1'b1;
                    c_ctl.upper   = !(sx < sbp);
                    sdiff = c_ctl.upper ? sc - sx : sx - sa;
                    c_num = sdiff[VB:0];
                    sdiff = sc - sa;
                    c_den = sdiff[VB:0];
                end
            end
            fmg_pkg::SHAPE_INV_QUAD:
            begin
                if (spread_reg == 16'd0)
                    c_ctl.cval = fmg_pkg::ONE;
                else if (dd_ext >= (VB+13)'(4096))
                    c_ctl.cval = '0;   // denominator beyond 2^24
                else
                begin
                    c_ctl.use_div = 1'b1;
                    c_iq = 1'b1;
                end
            end
            default: c_ctl.cval = '0;
        endcase
    end

    // elastic handshake through both stages
    logic v1_reg, v2_reg;
    logic r1, r2;
    assign r2        = !v2_reg || out_ready;
    assign r1        = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
        end
    end

    // stage 1: classified word and squared distance
    fmg_pkg::ctl_t ctl1_reg;
    logic [VB:0]   num1_reg, den1_reg;
    logic          iq1_reg;
    logic [23:0]   dsq1_reg;
    logic [15:0]   k1_reg;

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            ctl1_reg <= c_ctl;
            num1_reg <= c_num;
            den1_reg <= c_den;
            iq1_reg  <= c_iq;
            dsq1_reg <= c_dsq;
            k1_reg   <= spread_reg;
        end
    end

    // stage 2: k*d*d and final dividend/divisor
    logic [39:0] prod;
    logic [40:0] iq_sum;
    logic [24:0] iq_den;
    assign prod   = 40'(k1_reg * dsq1_reg);
    assign iq_sum = 41'(prod) + 41'd256;
    assign iq_den = (iq_sum[40:25] != '0) ? '1 : iq_sum[24:0];

    fmg_pkg::ctl_t ctl2_reg;
    logic [NW-1:0] num2_reg;
    logic [DW-1:0] den2_reg;

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            ctl2_reg <= ctl1_reg;
            num2_reg <= iq1_reg ? NW'(25'h1000000) : NW'({num1_reg, 16'h0000});
            den2_reg <= iq1_reg ? DW'(iq_den) : DW'(den1_reg);
        end
    end

    assign out_ctl = ctl2_reg;
    assign out_num = num2_reg;
    assign out_den = den2_reg;

endmodule : fmg_front
`default_nettype wire

[rtl/fmg_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmg_queue
// Four-word queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fmg_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic [W-1:0] mem [0:3];
    logic [1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [2:0]   count_reg;
    logic         push, pop;

    assign in_ready  = (count_reg != 3'd4);
    assign out_valid = (count_reg != 3'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_ptr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

endmodule : fmg_queue
`default_nettype wire

[rtl/fmg_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmg_back
// Pipelined restoring divider, one quotient bit per stage (17 stages), then
// a squaring stage and a saturate/invert stage. Stalls as one pipeline.
// ----------------------------------------------------------------------------
module fmg_back #(
    parameter int NW = 33,
    parameter int DW = 25
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fmg_pkg::ctl_t in_ctl,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [16:0]        out_grade
);

    localparam int RW = DW + 17;
    localparam int NS = 17;

    logic en;
    logic v_reg [0:NS+2];

    assign en       = !v_reg[NS+2] || out_ready;
    assign in_ready = en;

    logic [RW-1:0] rem_reg [0:NS];
    logic [DW-1:0] den_reg [0:NS];
    logic [16:0]   q_reg   [0:NS];
    fmg_pkg::ctl_t ctl_reg [0:NS+1];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS + 2; i++) v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NS + 2; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // divider entry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(in_num);
            den_reg[0] <= in_den;
            q_reg[0]   <= '0;
            ctl_reg[0] <= in_ctl;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < NS; s++)
    begin : g_div
        logic [RW-1:0] dsh;
        logic          take;
        assign dsh  = RW'(den_reg[s]) << (NS - 1 - s);
        assign take = (rem_reg[s] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= take ? rem_reg[s] - dsh : rem_reg[s];
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= q_reg[s] | (17'(take) << (NS - 1 - s));
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end
    end

    // squaring stage
    logic [16:0] base;
    logic [16:0] base_reg;
    logic [33:0] sq_reg;
    assign base = ctl_reg[NS].use_div ? q_reg[NS] : ctl_reg[NS].cval;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg      <= base;
            sq_reg        <= 34'(base * base);
            ctl_reg[NS+1] <= ctl_reg[NS];
        end
    end

    // saturate and invert
    logic [18:0] t;
    logic [16:0] g, gf;
    logic [16:0] grade_reg;

    always_comb
    begin
        t = sq_reg[33:15];
        if (!ctl_reg[NS+1].sq)
            g = base_reg;
        else if (ctl_reg[NS+1].upper)
            g = (t > 19'(fmg_pkg::ONE)) ? 17'd0 : 17'(19'(fmg_pkg::ONE) - t);
        else
            g = (t > 19'(fmg_pkg::ONE)) ? fmg_pkg::ONE : t[16:0];
        gf = ctl_reg[NS+1].invert ? fmg_pkg::ONE - g : g;
    end

    always_ff @(posedge clk)
    begin
        if (en) grade_reg <= gf;
    end

    assign out_valid = v_reg[NS+2];
    assign out_grade = grade_reg;

endmodule : fmg_back
`default_nettype wire

[rtl/fuzzy_membership_grade_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_membership_grade_unit_core
// Membership grade of one crisp sample for a configured fuzzy shape.
//
//   port group   dir  contents
//   s_axis_*     in   sample word
//   m_axis_*     out  grade word (65536 = 1.0)
//   cfg_*        in   register writes, index per register list
//
// One word per cycle sustained while the output is not stalled. From the
// accepting edge a sample passes the second front stage, queue write, divider
// entry, 17 divider stages (one quotient bit each), square and saturate
// stages. Reset clears all valid state; config resets to defaults.
// An output stall freezes the back end; the four-word queue lets the front
// end keep taking samples until it fills.
// ----------------------------------------------------------------------------
module fuzzy_membership_grade_unit_core #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [2:0]                          cfg_index,
    input  wire logic [((VALUE_BITS > 16) ? VALUE_BITS : 16)-1:0] cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [23:0]                              m_tdata   // grade
);

    localparam int CW = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    localparam int NW = VALUE_BITS + 17;
    localparam int DW = (VALUE_BITS + 1 > 25) ? VALUE_BITS + 1 : 25;
    localparam int QW = fmg_pkg::CTL_BITS + NW + DW;

    fmg_pkg::ctl_t f_ctl, b_ctl;
    logic [NW-1:0] f_num, b_num;
    logic [DW-1:0] f_den, b_den;
    logic          f_valid, f_ready, b_valid, b_ready;
    logic [16:0]   grade;

    fmg_front #(.VB(VALUE_BITS), .CW(CW), .NW(NW), .DW(DW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[VALUE_BITS-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_ctl   (f_ctl),
        .out_num   (f_num),
        .out_den   (f_den)
    );

    fmg_queue #(.W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctl, f_num, f_den}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  ({b_ctl, b_num, b_den})
    );

    fmg_back #(.NW(NW), .DW(DW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_ctl    (b_ctl),
        .in_num    (b_num),
        .in_den    (b_den),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_grade (grade)
    );

    assign m_tdata = {7'd0, grade};

endmodule : fuzzy_membership_grade_unit_core
`default_nettype wire

[rtl/fmg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmg_checker
// Port-level checks on the grade stream.
// ----------------------------------------------------------------------------
module fmg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("grade word changed under stall");

    // grade never above 1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
        else $error("grade above 1.0");

    // pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:17] == 7'd0)
        else $error("grade pad bits set");

    // nothing leaves during reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid in reset");

endmodule : fmg_checker

bind fuzzy_membership_grade_unit_core fmg_checker u_fmg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[tb/tb_fuzzy_membership_grade_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_membership_grade_unit_core
// Streams crisp samples through the membership grade unit for every shape,
// with degenerate and extreme breakpoints. Each accepted sample is graded by
// a local model and the result is checked against the grade word that comes
// out. Both stream sides idle and stall at random, except near the end.
// ----------------------------------------------------------------------------
module tb_fuzzy_membership_grade_unit_core;

    localparam longint GRADE_ONE = 65536;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] sample
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [16:0] grade, rest zero

    // local copy of the register file
    logic [2:0]  shape_r;
    logic [15:0] pa_r, pb_r, pc_r, pd_r, spread_r;

    logic [16:0] grade_q[$];
    logic [15:0] sample_q[$];
    int          mismatch_cnt;
    bit          src_idle_en;
    bit          sink_stall_en;

    fuzzy_membership_grade_unit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("fuzzy_membership_grade_unit_core: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------- model
    function automatic longint frac_q16(longint num, longint den);
        longint q;
        if (den == 0)
            return GRADE_ONE;
        q = (num << 16) / den;
        return (q > GRADE_ONE) ? GRADE_ONE : q;
    endfunction

    function automatic longint clamp_grade(longint g);
        if (g < 0)
            return 0;
        if (g > GRADE_ONE)
            return GRADE_ONE;
        return g;
    endfunction

    function automatic longint s_grade(longint x, longint a, longint b, longint c);
        longint f;
        if (x < a)
            return 0;
        if (x >= c)
            return GRADE_ONE;
        if (x < b)
        begin
            f = frac_q16(x - a, c - a);
            return clamp_grade((2 * f * f) >> 16);
        end
        f = frac_q16(c - x, c - a);
        return clamp_grade(GRADE_ONE - ((2 * f * f) >> 16));
    endfunction

    function automatic longint ramp_grade(longint x, longint a, longint b);
        if (x < a)
            return 0;
        if (x >= b)
            return GRADE_ONE;
        return frac_q16(x - a, b - a);
    endfunction

    function automatic logic [16:0] membership_grade(logic [15:0] sample);
        longint x, a, b, c, d, h, span, g;
        x = sample;
        a = pa_r;
        b = pb_r;
        c = pc_r;
        d = pd_r;
        g = 0;
        case (shape_r)
            fmg_pkg::SHAPE_RAMP_UP:   g = ramp_grade(x, a, b);
            fmg_pkg::SHAPE_RAMP_DOWN: g = GRADE_ONE - ramp_grade(x, a, b);
            fmg_pkg::SHAPE_TRIANGLE:
            begin
                if (x < a || x >= c)
                    g = 0;
                else if (x < b)
                    g = frac_q16(x - a, b - a);
                else
                    g = frac_q16(c - x, c - b);
            end
            fmg_pkg::SHAPE_TRAPEZOID:
            begin
                if (x < a || x >= d)
                    g = 0;
                else if (x >= b && x < c)
                    g = GRADE_ONE;
                else if (x < b)
                    g = frac_q16(x - a, b - a);
                else
                    g = frac_q16(d - x, d - c);
            end
            fmg_pkg::SHAPE_S_CURVE:   g = s_grade(x, a, b, c);
            fmg_pkg::SHAPE_S_BELL:
            begin
                h = b >> 1;
                if (x < c)
                    g = s_grade(x, c - b, c - h, c);
                else
                    g = GRADE_ONE - s_grade(x, c, c + h, c + b);
            end
            fmg_pkg::SHAPE_INV_QUAD:
            begin
                span = (x >= a) ? x - a : a - x;
                if (spread_r == 0)
                    g = GRADE_ONE;
                else
                    g = (longint'(1) << 24) / (256 + longint'(spread_r) * span * span);
            end
            default:         g = 0;
        endcase
        return g[16:0];
    endfunction

    // ---------------------------------------------------------------- checker
    always @(posedge clk)
    begin
        logic [16:0] want;
        logic [15:0] smp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grade_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected grade word %0d", m_tdata[16:0]);
            end
            else
            begin
                want = grade_q.pop_front();
                smp  = sample_q.pop_front();
                if (m_tdata[16:0] !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("shape %0d sample %0d: grade exp %0d got %0d",
                                 shape_r, smp, want, m_tdata[16:0]);
                end
            end
        end
    end

    // sink stalls
    initial
    begin
        m_tready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_stall_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- driving
    task automatic send_sample(logic [15:0] x);
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do
            @(posedge clk);
        while (!s_tready);
        grade_q.push_back(membership_grade(x));
        sample_q.push_back(x);
    endtask

    // stop the source and let every pending grade come out
    task automatic drain;
        s_tvalid <= 1'b0;
        while (grade_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // caller lowers cfg_we once the burst of writes is done
    task automatic write_reg(fmg_pkg::reg_idx_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            fmg_pkg::REG_SHAPE:  shape_r  = val[2:0];
            fmg_pkg::REG_A:      pa_r     = val;
            fmg_pkg::REG_B:      pb_r     = val;
            fmg_pkg::REG_C:      pc_r     = val;
            fmg_pkg::REG_D:      pd_r     = val;
            fmg_pkg::REG_SPREAD: spread_r = val;
            default: ;
        endcase
    endtask

    task automatic load_shape(logic [2:0] shp, logic [15:0] a, logic [15:0] b,
                              logic [15:0] c, logic [15:0] d, logic [15:0] k);
        drain();
        write_reg(fmg_pkg::REG_SHAPE, {13'd0, shp});
        write_reg(fmg_pkg::REG_A, a);
        write_reg(fmg_pkg::REG_B, b);
        write_reg(fmg_pkg::REG_C, c);
        write_reg(fmg_pkg::REG_D, d);
        write_reg(fmg_pkg::REG_SPREAD, k);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_ramps;
        load_shape(fmg_pkg::SHAPE_RAMP_UP, 16'd100, 16'd300, 16'd0, 16'd0, 16'd256);
        send_sample(16'd0);
        send_sample(16'd200);
        send_sample(16'hFFFF);
        load_shape(fmg_pkg::SHAPE_RAMP_DOWN, 16'd500, 16'd500, 16'd0, 16'd0, 16'd256);
        send_sample(16'd499);
        send_sample(16'd500);
    endtask

    task automatic test_triangle_trapezoid;
        load_shape(fmg_pkg::SHAPE_TRIANGLE, 16'd0, 16'd1000, 16'hFFFF, 16'd0, 16'd256);
        send_sample(16'd1);
        send_sample(16'd1000);
        send_sample(16'hFFFE);
        load_shape(fmg_pkg::SHAPE_TRAPEZOID, 16'd10, 16'd10, 16'd20, 16'd20, 16'd256);
        send_sample(16'd10);
        send_sample(16'd19);
        send_sample(16'd20);
    endtask

    // includes a midpoint far off center
    task automatic test_s_shapes;
        load_shape(fmg_pkg::SHAPE_S_CURVE, 16'd0, 16'd10, 16'd1000, 16'd0, 16'd256);
        send_sample(16'd9);
        send_sample(16'd500);
        send_sample(16'd999);
        load_shape(fmg_pkg::SHAPE_S_BELL, 16'd0, 16'hFFFF, 16'd100, 16'd0, 16'd256);
        send_sample(16'd0);
        send_sample(16'd100);
        send_sample(16'hFFFF);
    endtask

    // zero spread, widest spread and farthest distance
    task automatic test_inv_quad;
        load_shape(fmg_pkg::SHAPE_INV_QUAD, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'hFFFF);
        load_shape(fmg_pkg::SHAPE_INV_QUAD, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_sample(16'd0);
        send_sample(16'hFFFE);
    endtask

    // shape code 7 and writes to indexes past the register list
    task automatic test_unused_codes;
        load_shape(3'd7, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5);
        send_sample(16'd3);
        drain();
        write_reg(fmg_pkg::reg_idx_t'(3'd6), 16'hFFFF);
        write_reg(fmg_pkg::reg_idx_t'(3'd7), 16'h0000);
        write_reg(fmg_pkg::REG_SHAPE, {13'd0, fmg_pkg::SHAPE_RAMP_UP});
        cfg_we <= 1'b0;
        send_sample(16'd2);
    endtask

    function automatic logic [15:0] pick_point();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        logic [15:0] p;
        case ($urandom_range(0, 7))
            0:       p = pa_r;
            1:       p = pb_r;
            2:       p = pc_r;
            3:       p = pd_r;
            4:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
            default: return 16'($urandom);
        endcase
        return p + 16'($signed($urandom_range(0, 8)) - 4);
    endfunction

    task automatic test_random;
        logic [15:0] pts[4];
        logic [15:0] tmp;
        logic [15:0] k;
        for (int ph = 0; ph < 20; ph++)
        begin
            foreach (pts[i])
                pts[i] = pick_point();
            // mostly ordered breakpoints; the rest stay degenerate or crossed
            if ($urandom_range(0, 3) != 0)
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 3 - i; j++)
                        if (pts[j] > pts[j + 1])
                        begin
                            tmp = pts[j];
                            pts[j] = pts[j + 1];
                            pts[j + 1] = tmp;
                        end
            case ($urandom_range(0, 3))
                0:       k = 16'd0;
                1:       k = 16'hFFFF;
                2:       k = 16'($urandom_range(1, 512));
                default: k = 16'($urandom);
            endcase
            if (ph >= 16)
            begin
                src_idle_en   = 1'b0;
                sink_stall_en = 1'b0;
            end
            load_shape(3'($urandom_range(0, 7)), pts[0], pts[1], pts[2], pts[3], k);
            for (int n = 0; n < 20; n++)
                send_sample(pick_sample());
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = fmg_pkg::REG_SHAPE;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        mismatch_cnt  = 0;
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        shape_r       = fmg_pkg::SHAPE_RAMP_UP;
        pa_r          = '0;
        pb_r          = '0;
        pc_r          = '0;
        pd_r          = '0;
        spread_r      = 16'd256;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults, before any write
        send_sample(16'd0);
        test_ramps();
        test_triangle_trapezoid();
        test_s_shapes();
        test_inv_quad();
        test_unused_codes();
        test_random();

        drain();
        repeat (30) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("fuzzy_membership_grade_unit_core: match");
        else
            $display("fuzzy_membership_grade_unit_core: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/fmg_pkg.sv
rtl/fmg_front.sv
rtl/fmg_queue.sv
rtl/fmg_back.sv
rtl/fuzzy_membership_grade_unit_core.sv
rtl/fmg_checker.sv
tb/tb_fuzzy_membership_grade_unit_core.sv
